@@ hdl/sle_pkg.sv @@
`timescale 1ns / 1ps

package sle_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;
    localparam int VALUE_W        = 32;
    localparam int COUNT_OUT_W    = 7;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Broadcast from the control to every cell of the chain.
    typedef struct packed {
        logic fire;
        t_op  op;
        logic full;
        logic found;
    } t_cell_ctl;

endpackage

@@ hdl/sle_cell.sv @@
`timescale 1ns / 1ps

module sle_cell #(
    parameter int IDX        = 0,
    parameter int VALUE_BITS = sle_pkg::VALUE_BITS_DEF,
    parameter int COUNT_W    = 7
) (
    input  logic                  i_clk,
    input  sle_pkg::t_cell_ctl    i_ctl,
    input  logic [VALUE_BITS-1:0] i_key,
    input  logic [COUNT_W-1:0]    i_count,
    input  logic [VALUE_BITS-1:0] i_left_entry,
    input  logic                  i_left_le,
    input  logic [VALUE_BITS-1:0] i_right_entry,
    output logic [VALUE_BITS-1:0] o_entry,
    output logic                  o_le,
    output logic                  o_eq
);

    logic [VALUE_BITS-1:0] r_entry;
    logic [VALUE_BITS-1:0] n_entry;
    logic                  w_valid;
    logic                  w_ge;

    assign w_valid = (i_count > COUNT_W'(IDX));
    assign o_le    = w_valid && ($signed(r_entry) <= $signed(i_key));
    assign o_eq    = w_valid && (r_entry == i_key);
    assign w_ge    = w_valid && ($signed(r_entry) >= $signed(i_key));
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.fire) begin
            case (i_ctl.op)
                sle_pkg::OP_INSERT: begin
                    // keep smaller-or-equal entries, drop key at the boundary, shift the rest up
                    if (!i_ctl.full && !o_le) begin
                        n_entry = i_left_le ? i_key : i_left_entry;
                    end
                end
                sle_pkg::OP_REMOVE: begin
                    // close the gap from the first equal entry upward
                    if (i_ctl.found && w_ge) begin
                        n_entry = i_right_entry;
                    end
                end
                default: n_entry = r_entry;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

@@ hdl/sorted_list_engine_unit.sv @@
`timescale 1ns / 1ps

// Channel   Ports                                        Handshake
// request   i_operation, i_value                         start & !busy
// result    o_status, o_found, o_entry_count, o_empty_res  o_done, one cycle
//
// One request per clock: busy stays low. A request is latched at the edge that
// accepts it; on the next edge every cell of the chain compares against the key;
// an insert or remove shifts it left or right in one step, and o_done and the
// result are registered at that edge. Reset clears the entry count; cell contents
// stay unknown until written. The receiver cannot stall the result.

module sorted_list_engine_unit #(
    parameter int CAPACITY   = sle_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = sle_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_operation,
    input  logic [sle_pkg::VALUE_W-1:0]  i_value,
    output logic                         o_done,
    output logic [1:0]                   o_status,
    output logic                         o_found,
    output logic [sle_pkg::COUNT_OUT_W-1:0] o_entry_count,
    output logic                         o_empty_res
);

    localparam int COUNT_W = $clog2(CAPACITY + 1);

    logic                  r_req_vld;
    sle_pkg::t_op          r_op;
    logic [VALUE_BITS-1:0] r_key;
    logic [VALUE_BITS-1:0] w_key;
    logic [COUNT_W-1:0]    r_count;
    logic [COUNT_W-1:0]    n_count;
    logic                  r_done;
    sle_pkg::t_status      r_status;
    sle_pkg::t_status      n_status;
    logic                  r_found;
    logic                  w_full;
    logic                  w_found;
    sle_pkg::t_cell_ctl    w_ctl;

    logic [VALUE_BITS-1:0] w_entry [CAPACITY];
    logic [CAPACITY-1:0]   w_le;
    logic [CAPACITY-1:0]   w_eq;

    // sign-extend or truncate the request value to the stored width
    generate
        if (VALUE_BITS <= sle_pkg::VALUE_W) begin : g_key_narrow
            assign w_key = i_value[VALUE_BITS-1:0];
        end else begin : g_key_wide
            assign w_key = {{(VALUE_BITS - sle_pkg::VALUE_W){i_value[sle_pkg::VALUE_W-1]}},
                            i_value};
        end
    endgenerate

    assign busy    = 1'b0;
    assign w_full  = (r_count == COUNT_W'(CAPACITY));
    assign w_found = |w_eq;

    assign w_ctl.fire  = r_req_vld;
    assign w_ctl.op    = r_op;
    assign w_ctl.full  = w_full;
    assign w_ctl.found = w_found;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [VALUE_BITS-1:0] w_left_entry;
            logic                  w_left_le;
            logic [VALUE_BITS-1:0] w_right_entry;

            if (gi == 0) begin : g_first
                assign w_left_entry = r_key;
                assign w_left_le    = 1'b1;
            end else begin : g_mid
                assign w_left_entry = w_entry[gi-1];
                assign w_left_le    = w_le[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign w_right_entry = w_entry[gi];
            end else begin : g_inner
                assign w_right_entry = w_entry[gi+1];
            end

            sle_cell #(
                .IDX        (gi),
                .VALUE_BITS (VALUE_BITS),
                .COUNT_W    (COUNT_W)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_key         (r_key),
                .i_count       (r_count),
                .i_left_entry  (w_left_entry),
                .i_left_le     (w_left_le),
                .i_right_entry (w_right_entry),
                .o_entry       (w_entry[gi]),
                .o_le          (w_le[gi]),
                .o_eq          (w_eq[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = sle_pkg::ST_OK;
        case (r_op)
            sle_pkg::OP_INSERT: begin
                if (w_full) begin
                    n_status = sle_pkg::ST_FULL;
                end else begin
                    n_count = r_count + COUNT_W'(1);
                end
            end
            sle_pkg::OP_REMOVE: begin
                if (w_found) begin
                    n_count = r_count - COUNT_W'(1);
                end else begin
                    n_status = sle_pkg::ST_NOT_FOUND;
                end
            end
            sle_pkg::OP_CONTAINS: begin
                if (!w_found) begin
                    n_status = sle_pkg::ST_NOT_FOUND;
                end
            end
            sle_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_done    <= 1'b0;
            r_count   <= '0;
        end else begin
            r_req_vld <= start && !busy;
            r_done    <= r_req_vld;
            if (r_req_vld) begin
                r_count <= n_count;
            end
        end
    end

    // payload: latch the request, hold the result until the next one
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op  <= sle_pkg::t_op'(i_operation);
            r_key <= w_key;
        end
        if (r_req_vld) begin
            r_status <= n_status;
            r_found  <= w_found;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_entry_count = sle_pkg::COUNT_OUT_W'(r_count);
    assign o_empty_res   = (r_count == '0);

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_done_follows_req : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_vld |=> o_done)
        else $error("latched request produced no result");

    a_full_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == sle_pkg::ST_FULL) |-> (r_count == COUNT_W'(CAPACITY)))
        else $error("full status while list not full");

    a_remove_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_vld && r_op == sle_pkg::OP_REMOVE && w_found)
            |=> (r_count == $past(r_count) - COUNT_W'(1)))
        else $error("remove of a present value did not shrink the list");

endmodule
